/* rtl/biq_pkg.sv */
// shared types and constants of the biquad filter
`default_nettype none

package biq_pkg;

   // coefficient register index, byte address divided by four
   typedef enum logic [2:0] {
      REG_B0 = 3'd0,
      REG_B1 = 3'd1,
      REG_B2 = 3'd2,
      REG_A1 = 3'd3,
      REG_A2 = 3'd4
   } reg_index_type;

   // fill state of the queue between front and back end
   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   // entries of the queue between front and back end
   localparam int QUEUE_DEPTH = 2;

   // byte address bits of the configuration port
   localparam int CSR_ADDR_BITS = 5;

   // data width of the configuration port
   localparam int CSR_DATA_BITS = 32;

endpackage

`default_nettype wire

/* rtl/biquad_iir_filter.sv */
// top level of the direct form one biquad filter
//
// Input channel req_: one signed sample per transfer (req_valid, req_stall).
// Result channel rsp_: one filtered sample and a clip flag per input,
// in input order (rsp_valid, rsp_stall).
// csr_: APB-style port, five signed coefficients b0 b1 b2 a1 a2 at byte
// addresses 0, 4, 8, 12, 16; pready is always high, reads return the
// coefficient sign-extended. Write coefficients only while no sample is in
// flight.
// A result passes the front stage, the queue and the output register.
// One sample per cycle unless stalled; the limit is the back end loop of
// the a1 product on the last output, the five-term sum, rounding and
// clamping. The front end forms the feedforward products a stage earlier.
// Reset clears coefficients, both histories, the queue and all valids.
// When the receiver stalls, the output register holds its result, the
// two-entry queue and the front stage fill, and req_stall then rises.
`default_nettype none

module biquad_iir_filter #(
   parameter int SAMPLE_BITS    = 24,
   parameter int COEF_FRAC_BITS = 22
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [SAMPLE_BITS-1:0]        req_in_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]        rsp_out_sample,
   output logic                                 rsp_clipped,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [biq_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [biq_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [biq_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                 csr_pready
);
   import biq_pkg::*;

   localparam int COEF_BITS = COEF_FRAC_BITS + 2;
   localparam int FF_W      = SAMPLE_BITS + COEF_BITS + 2;
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   logic signed [COEF_BITS-1:0] coef_b0_ff, coef_b0_in;
   logic signed [COEF_BITS-1:0] coef_b1_ff, coef_b1_in;
   logic signed [COEF_BITS-1:0] coef_b2_ff, coef_b2_in;
   logic signed [COEF_BITS-1:0] coef_a1_ff, coef_a1_in;
   logic signed [COEF_BITS-1:0] coef_a2_ff, coef_a2_in;
   logic signed [COEF_BITS-1:0] wr_coef;
   logic                        csr_write;
   reg_index_type               csr_index;
   fifo_status_type             q_status;
   logic                        q_push, q_pop;
   logic signed [FF_W-1:0]      q_push_data, q_pop_data;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = reg_index_type'(csr_paddr[CSR_ADDR_BITS-1:2]);
   assign wr_coef    = csr_pwdata[COEF_BITS-1:0];

   // coefficient write decode
   always_comb begin
      coef_b0_in = coef_b0_ff;
      coef_b1_in = coef_b1_ff;
      coef_b2_in = coef_b2_ff;
      coef_a1_in = coef_a1_ff;
      coef_a2_in = coef_a2_ff;
      if (csr_write) begin
         case (csr_index)
            REG_B0:  coef_b0_in = wr_coef;
            REG_B1:  coef_b1_in = wr_coef;
            REG_B2:  coef_b2_in = wr_coef;
            REG_A1:  coef_a1_in = wr_coef;
            REG_A2:  coef_a2_in = wr_coef;
            default: coef_b0_in = coef_b0_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_b0_ff <= '0;
         coef_b1_ff <= '0;
         coef_b2_ff <= '0;
         coef_a1_ff <= '0;
         coef_a2_ff <= '0;
      end else begin
         coef_b0_ff <= coef_b0_in;
         coef_b1_ff <= coef_b1_in;
         coef_b2_ff <= coef_b2_in;
         coef_a1_ff <= coef_a1_in;
         coef_a2_ff <= coef_a2_in;
      end
   end

   // read back, sign-extended
   always_comb begin
      case (csr_index)
         REG_B0:  csr_prdata = CSR_DATA_BITS'(coef_b0_ff);
         REG_B1:  csr_prdata = CSR_DATA_BITS'(coef_b1_ff);
         REG_B2:  csr_prdata = CSR_DATA_BITS'(coef_b2_ff);
         REG_A1:  csr_prdata = CSR_DATA_BITS'(coef_a1_ff);
         REG_A2:  csr_prdata = CSR_DATA_BITS'(coef_a2_ff);
         default: csr_prdata = '0;
      endcase
   end

   // front end
   biq_front #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COEF_BITS   (COEF_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_in_sample (req_in_sample),
      .coef_b0       (coef_b0_ff),
      .coef_b1       (coef_b1_ff),
      .coef_b2       (coef_b2_ff),
      .q_status      (q_status),
      .push          (q_push),
      .push_data     (q_push_data)
   );

   // queue between the two halves
   biq_queue #(
      .WIDTH (FF_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .status    (q_status)
   );

   // back end
   biq_back #(
      .SAMPLE_BITS    (SAMPLE_BITS),
      .COEF_FRAC_BITS (COEF_FRAC_BITS),
      .COEF_BITS      (COEF_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_status       (q_status),
      .pop_data       (q_pop_data),
      .pop            (q_pop),
      .coef_a1        (coef_a1_ff),
      .coef_a2        (coef_a2_ff),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_sample (rsp_out_sample),
      .rsp_clipped    (rsp_clipped)
   );

   // queue can never be full and empty at once
   a_queue_status: assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("queue reports full and empty together");

   // an entry written into the queue is there on the next cycle
   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      (q_push && !q_status.full) |=> !q_status.empty)
      else $error("queue empty after a transfer into it");

   // a clipped result sits on one of the range bounds
   a_clip_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_clipped) |->
         (rsp_out_sample == SAMPLE_MAX || rsp_out_sample == SAMPLE_MIN))
      else $error("clipped result not at a range bound");

endmodule

`default_nettype wire

/* rtl/biq_front.sv */
// front end: takes input transfers, keeps input history, forms the feedforward sum
`default_nettype none

module biq_front #(
   parameter int SAMPLE_BITS = 24,
   parameter int COEF_BITS   = 24
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [SAMPLE_BITS-1:0]           req_in_sample,
   input  logic signed [COEF_BITS-1:0]             coef_b0,
   input  logic signed [COEF_BITS-1:0]             coef_b1,
   input  logic signed [COEF_BITS-1:0]             coef_b2,
   input  biq_pkg::fifo_status_type                q_status,
   output logic                                    push,
   output logic signed [SAMPLE_BITS+COEF_BITS+1:0] push_data
);
   import biq_pkg::*;

   localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
   localparam int FF_W   = PROD_W + 2;

   logic                          accept;
   logic                          fe_valid_ff, fe_valid_in;
   logic signed [SAMPLE_BITS-1:0] x1_ff, x1_in;
   logic signed [SAMPLE_BITS-1:0] x2_ff, x2_in;
   logic signed [PROD_W-1:0]      p0_ff, p0_in;
   logic signed [PROD_W-1:0]      p1_ff, p1_in;
   logic signed [PROD_W-1:0]      p2_ff, p2_in;
   fifo_status_type               status;

   assign status = q_status;

   // handshake: hold off while the staged item cannot move on
   assign req_stall = fe_valid_ff & status.full;
   assign accept    = req_valid & ~req_stall;
   assign push      = fe_valid_ff & ~status.full;

   // next values of the stage and the input history
   always_comb begin
      fe_valid_in = accept | (fe_valid_ff & status.full);
      x1_in       = x1_ff;
      x2_in       = x2_ff;
      p0_in       = p0_ff;
      p1_in       = p1_ff;
      p2_in       = p2_ff;
      if (accept) begin
         x1_in = req_in_sample;
         x2_in = x1_ff;
         p0_in = coef_b0 * req_in_sample;
         p1_in = coef_b1 * x1_ff;
         p2_in = coef_b2 * x2_ff;
      end
   end

   // control state and history
   always_ff @(posedge clock) begin
      if (reset) begin
         fe_valid_ff <= 1'b0;
         x1_ff       <= '0;
         x2_ff       <= '0;
      end else begin
         fe_valid_ff <= fe_valid_in;
         x1_ff       <= x1_in;
         x2_ff       <= x2_in;
      end
   end

   // product registers
   always_ff @(posedge clock) begin
      p0_ff <= p0_in;
      p1_ff <= p1_in;
      p2_ff <= p2_in;
   end

   // feedforward sum handed to the queue
   assign push_data = FF_W'(p0_ff) + FF_W'(p1_ff) + FF_W'(p2_ff);

endmodule

`default_nettype wire

/* rtl/biq_queue.sv */
// short queue between front and back end
`default_nettype none

module biq_queue #(
   parameter int WIDTH = 50
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  logic [WIDTH-1:0]         push_data,
   input  logic                     pop,
   output logic [WIDTH-1:0]         pop_data,
   output biq_pkg::fifo_status_type status
);
   import biq_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   logic [WIDTH-1:0] mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign status.full  = (count_ff == FULL_CNT);
   assign status.empty = (count_ff == '0);
   assign do_push      = push & ~status.full;
   assign do_pop       = pop & ~status.empty;
   assign pop_data     = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

/* rtl/biq_back.sv */
// back end: feedback terms, rounding, saturation and output register
`default_nettype none

module biq_back #(
   parameter int SAMPLE_BITS    = 24,
   parameter int COEF_FRAC_BITS = 22,
   parameter int COEF_BITS      = 24
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  biq_pkg::fifo_status_type                q_status,
   input  logic signed [SAMPLE_BITS+COEF_BITS+1:0] pop_data,
   output logic                                    pop,
   input  logic signed [COEF_BITS-1:0]             coef_a1,
   input  logic signed [COEF_BITS-1:0]             coef_a2,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]           rsp_out_sample,
   output logic                                    rsp_clipped
);
   import biq_pkg::*;

   localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
   localparam int ACC_W  = PROD_W + 3;
   localparam int HI_LSB = COEF_FRAC_BITS + SAMPLE_BITS - 1;
   localparam logic signed [ACC_W-1:0] ROUND_HALF =
      {{(ACC_W-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   fifo_status_type               status;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] out_ff, out_in;
   logic                          clip_ff, clip_in;
   logic signed [SAMPLE_BITS-1:0] y1_ff, y1_in;
   logic signed [SAMPLE_BITS-1:0] y2_ff, y2_in;
   logic signed [PROD_W-1:0]      a2y2_ff, a2y2_in;
   logic signed [PROD_W-1:0]      fb1;
   logic signed [ACC_W-1:0]       acc;
   logic [ACC_W-1-HI_LSB:0]       acc_hi;
   logic                          fits;
   logic signed [SAMPLE_BITS-1:0] y;
   logic                          clip;

   assign status = q_status;

   // take the next entry while the output register is free or drains
   assign pop = ~status.empty & (~rsp_valid_ff | ~rsp_stall);

   // feedback sum with half lsb for rounding
   assign fb1 = coef_a1 * y1_ff;
   assign acc = ACC_W'(pop_data) - ACC_W'(fb1) - ACC_W'(a2y2_ff) + ROUND_HALF;

   // shift down by the fraction bits and clamp to the sample range
   assign acc_hi = acc[ACC_W-1:HI_LSB];
   assign fits   = (&acc_hi) | ~(|acc_hi);
   assign clip   = ~fits;
   assign y      = fits ? acc[HI_LSB:COEF_FRAC_BITS]
                        : (acc[ACC_W-1] ? SAMPLE_MIN : SAMPLE_MAX);

   // next values of history, output register and second feedback product
   always_comb begin
      rsp_valid_in = pop | (rsp_valid_ff & rsp_stall);
      y1_in        = y1_ff;
      y2_in        = y2_ff;
      out_in       = out_ff;
      clip_in      = clip_ff;
      if (pop) begin
         y1_in   = y;
         y2_in   = y1_ff;
         out_in  = y;
         clip_in = clip;
      end
      // always recomputed, so it follows coefficient writes too
      a2y2_in = coef_a2 * y2_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         y1_ff        <= '0;
         y2_ff        <= '0;
         a2y2_ff      <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         y1_ff        <= y1_in;
         y2_ff        <= y2_in;
         a2y2_ff      <= a2y2_in;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      clip_ff <= clip_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_sample = out_ff;
   assign rsp_clipped    = clip_ff;

endmodule

`default_nettype wire
